### hw/rtl/ahw_pkg.sv
// ----------------------------------------------------------------------------
// ahw_pkg
// Shared types and constants of the archive header walker.
// ----------------------------------------------------------------------------
package ahw_pkg;

    localparam logic [7:0] FILE_BLOCK_TYPE = 8'h74;
    localparam logic [7:0] LIMIT_RESET     = 8'd3;
    localparam logic [15:0] BASE_LEN       = 16'd7;

    localparam logic [4:0] OFF_TYPE        = 5'd2;
    localparam logic [4:0] OFF_HSIZE_LO    = 5'd5;
    localparam logic [4:0] OFF_HSIZE_HI    = 5'd6;
    localparam logic [4:0] OFF_PSIZE_END   = 5'd4;
    localparam logic [4:0] OFF_NLEN_LO     = 5'd19;
    localparam logic [4:0] OFF_NLEN_HI     = 5'd20;
    localparam logic [4:0] OFF_TOTAL       = 5'd21;
    localparam logic [4:0] OFF_SPAN        = 5'd22;
    localparam logic [4:0] OFF_FHEAD_LAST  = 5'd24;

    localparam logic [16:0] HEADS_LEN      = 17'd32;

    localparam logic [2:0] ADDR_FILE_LIMIT = 3'd0;

    typedef enum logic [4:0] {
        PH_BASE  = 5'b00001,
        PH_FHEAD = 5'b00010,
        PH_NAME  = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_STOP  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_last;
        logic [7:0] file_index;
    } t_result;

endpackage

### hw/rtl/ahw_cfg.sv
// ----------------------------------------------------------------------------
// ahw_cfg
// APB-style register port holding the file limit.
// ----------------------------------------------------------------------------
module ahw_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_file_limit
);

    logic [7:0] r_file_limit;
    logic       w_hit;

    assign w_hit  = (paddr[2] == ahw_pkg::ADDR_FILE_LIMIT[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_limit <= ahw_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_file_limit <= pwdata[7:0];
        end
    end

    assign prdata       = w_hit ? {24'd0, r_file_limit} : 32'd0;
    assign o_file_limit = r_file_limit;

endmodule

### hw/rtl/ahw_parser.sv
// ----------------------------------------------------------------------------
// ahw_parser
// Header walking state machine with its result register.
// ----------------------------------------------------------------------------
module ahw_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output logic             o_ready,
    input  logic [7:0]       i_file_limit,
    output logic             o_valid,
    input  logic             i_out_ready,
    output ahw_pkg::t_result o_result
);

    ahw_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_off, n_off;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_head, n_head;
    logic [31:0] r_packed, n_packed;
    logic [15:0] r_nlen, n_nlen;
    logic [32:0] r_rem, n_rem;
    logic [7:0]  r_files, n_files;
    logic [32:0] r_total, n_total;
    logic [32:0] r_span, n_span;
    logic        r_out_valid;
    ahw_pkg::t_result r_out;

    logic        w_fire;
    logic        w_emit;
    logic [15:0] w_head_new;
    logic [15:0] w_head_eff;
    logic [15:0] w_base_span;
    logic [33:0] w_diff;
    logic [7:0]  w_count;
    logic        w_stop;

    assign o_ready = !r_out_valid || i_out_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_head_new  = {i_byte, r_head[7:0]};
    assign w_head_eff  = (w_head_new < ahw_pkg::BASE_LEN) ? ahw_pkg::BASE_LEN : w_head_new;
    assign w_base_span = w_head_eff - ahw_pkg::BASE_LEN;
    assign w_diff  = {1'b0, r_total} - {17'd0, ahw_pkg::HEADS_LEN + {1'b0, r_nlen}};
    assign w_count = r_files + 8'd1;
    assign w_stop  = (i_file_limit != 8'd0) && (w_count >= i_file_limit);

    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_type   = r_type;
        n_head   = r_head;
        n_packed = r_packed;
        n_nlen   = r_nlen;
        n_rem    = r_rem;
        n_files  = r_files;
        n_total  = r_total;
        n_span   = r_span;
        w_emit   = 1'b0;
        if (w_fire) begin
            unique case (r_phase)
                ahw_pkg::PH_BASE: begin
                    if (r_off == ahw_pkg::OFF_TYPE) begin
                        n_type = i_byte;
                    end
                    if (r_off == ahw_pkg::OFF_HSIZE_LO) begin
                        n_head = {r_head[15:8], i_byte};
                    end
                    n_off = r_off + 5'd1;
                    if (r_off == ahw_pkg::OFF_HSIZE_HI) begin
                        n_head = w_head_eff;
                        n_off  = 5'd0;
                        if (r_type == ahw_pkg::FILE_BLOCK_TYPE) begin
                            n_packed = 32'd0;
                            n_nlen   = 16'd0;
                            n_phase  = ahw_pkg::PH_FHEAD;
                        end else begin
                            n_rem   = {17'd0, w_base_span};
                            n_phase = (w_base_span != 16'd0) ? ahw_pkg::PH_SKIP
                                                             : ahw_pkg::PH_BASE;
                        end
                    end
                end
                ahw_pkg::PH_FHEAD: begin
                    if (r_off < ahw_pkg::OFF_PSIZE_END) begin
                        n_packed[8*r_off[1:0] +: 8] = i_byte;
                    end
                    if (r_off == ahw_pkg::OFF_NLEN_LO) begin
                        n_nlen = {r_nlen[15:8], i_byte};
                    end
                    if (r_off == ahw_pkg::OFF_NLEN_HI) begin
                        n_nlen = {i_byte, r_nlen[7:0]};
                    end
                    if (r_off == ahw_pkg::OFF_TOTAL) begin
                        n_total = {17'd0, r_head} + {1'b0, r_packed};
                    end
                    if (r_off == ahw_pkg::OFF_SPAN) begin
                        n_span = w_diff[33] ? 33'd0 : w_diff[32:0];
                    end
                    n_off = r_off + 5'd1;
                    if (r_off == ahw_pkg::OFF_FHEAD_LAST) begin
                        n_off = 5'd0;
                        if (r_nlen == 16'd0) begin
                            n_files = w_count;
                            if (w_stop) begin
                                n_rem   = 33'd0;
                                n_phase = ahw_pkg::PH_STOP;
                            end else begin
                                n_rem   = r_span;
                                n_phase = (r_span != 33'd0) ? ahw_pkg::PH_SKIP
                                                            : ahw_pkg::PH_BASE;
                            end
                        end else begin
                            n_rem   = {17'd0, r_nlen};
                            n_phase = ahw_pkg::PH_NAME;
                        end
                    end
                end
                ahw_pkg::PH_NAME: begin
                    w_emit = 1'b1;
                    if (r_rem <= 33'd1) begin
                        n_off   = 5'd0;
                        n_files = w_count;
                        if (w_stop) begin
                            n_rem   = 33'd0;
                            n_phase = ahw_pkg::PH_STOP;
                        end else begin
                            n_rem   = r_span;
                            n_phase = (r_span != 33'd0) ? ahw_pkg::PH_SKIP
                                                        : ahw_pkg::PH_BASE;
                        end
                    end else begin
                        n_rem = r_rem - 33'd1;
                    end
                end
                ahw_pkg::PH_SKIP: begin
                    if (r_rem <= 33'd1) begin
                        n_rem   = 33'd0;
                        n_off   = 5'd0;
                        n_phase = ahw_pkg::PH_BASE;
                    end else begin
                        n_rem = r_rem - 33'd1;
                    end
                end
                ahw_pkg::PH_STOP: begin
                    n_phase = ahw_pkg::PH_STOP;
                end
                default: begin
                    n_phase = ahw_pkg::PH_BASE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ahw_pkg::PH_BASE;
            r_off       <= 5'd0;
            r_type      <= 8'd0;
            r_head      <= 16'd0;
            r_packed    <= 32'd0;
            r_nlen      <= 16'd0;
            r_rem       <= 33'd0;
            r_files     <= 8'd0;
            r_total     <= 33'd0;
            r_span      <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_type   <= n_type;
            r_head   <= n_head;
            r_packed <= n_packed;
            r_nlen   <= n_nlen;
            r_rem    <= n_rem;
            r_files  <= n_files;
            r_total  <= n_total;
            r_span   <= n_span;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.name_byte  <= i_byte;
            r_out.name_last  <= (r_rem <= 33'd1);
            r_out.file_index <= r_files;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### hw/rtl/archive_header_walker_core.sv
// ----------------------------------------------------------------------------
// archive_header_walker_core
// Walks archive block headers and emits the stored name of each file block, up to the file limit.
// ----------------------------------------------------------------------------
// Archive bytes enter on the input channel (i_in_valid, o_in_ready,
// i_stream_byte), one item per byte. Each name byte of a file block leaves
// on the output channel (o_out_valid, i_out_ready) with its last flag and
// the file ordinal; all other bytes produce no item.
// A byte is taken into an input register and decoded by the header state
// machine when the parser is ready. A resulting name item is loaded into
// the result register at the end of that decode cycle and offered from there.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item and the
// input register takes at most one more byte; after that o_in_ready drops.
// Reset clears the pipeline and parse state and sets the file limit to
// three; zero means no limit. The user writes the file limit through the
// APB port at address 0 while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
module archive_header_walker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_name_byte,
    output logic        o_name_last,
    output logic [7:0]  o_file_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_parse_ready;
    logic [7:0] w_file_limit;
    ahw_pkg::t_result w_result;

    assign o_in_ready = !r_in_valid || w_parse_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_stream_byte;
        end
    end

    ahw_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_file_limit (w_file_limit)
    );

    ahw_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_byte       (r_in_byte),
        .o_ready      (w_parse_ready),
        .i_file_limit (w_file_limit),
        .o_valid      (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (w_result)
    );

    assign o_name_byte  = w_result.name_byte;
    assign o_name_last  = w_result.name_last;
    assign o_file_index = w_result.file_index;

endmodule
